// File: hdl/tekd_pkg.sv
package tekd_pkg;

  localparam int KeyW  = 9;
  localparam int ByteW = 8;

  localparam logic [ByteW-1:0] CH_ESC   = 8'h1b;
  localparam logic [ByteW-1:0] CH_LBRK  = 8'h5b;
  localparam logic [ByteW-1:0] CH_O     = 8'h4f;
  localparam logic [ByteW-1:0] CH_TILDE = 8'h7e;
  localparam logic [ByteW-1:0] CH_SEMI  = 8'h3b;
  localparam logic [ByteW-1:0] CH_0     = 8'h30;
  localparam logic [ByteW-1:0] CH_1     = 8'h31;
  localparam logic [ByteW-1:0] CH_3     = 8'h33;
  localparam logic [ByteW-1:0] CH_4     = 8'h34;
  localparam logic [ByteW-1:0] CH_5     = 8'h35;
  localparam logic [ByteW-1:0] CH_6     = 8'h36;
  localparam logic [ByteW-1:0] CH_7     = 8'h37;
  localparam logic [ByteW-1:0] CH_8     = 8'h38;
  localparam logic [ByteW-1:0] CH_9     = 8'h39;
  localparam logic [ByteW-1:0] CH_A     = 8'h41;
  localparam logic [ByteW-1:0] CH_B     = 8'h42;
  localparam logic [ByteW-1:0] CH_C     = 8'h43;
  localparam logic [ByteW-1:0] CH_D     = 8'h44;
  localparam logic [ByteW-1:0] CH_F     = 8'h46;
  localparam logic [ByteW-1:0] CH_H     = 8'h48;

  localparam logic [KeyW-1:0] KEY_NONE   = 9'd0;
  localparam logic [KeyW-1:0] KEY_ESC    = 9'd27;
  localparam logic [KeyW-1:0] KEY_LEFT   = 9'd256;
  localparam logic [KeyW-1:0] KEY_RIGHT  = 9'd257;
  localparam logic [KeyW-1:0] KEY_UP     = 9'd258;
  localparam logic [KeyW-1:0] KEY_DOWN   = 9'd259;
  localparam logic [KeyW-1:0] KEY_DEL    = 9'd260;
  localparam logic [KeyW-1:0] KEY_HOME   = 9'd261;
  localparam logic [KeyW-1:0] KEY_END    = 9'd262;
  localparam logic [KeyW-1:0] KEY_PGUP   = 9'd263;
  localparam logic [KeyW-1:0] KEY_PGDN   = 9'd264;
  localparam logic [KeyW-1:0] KEY_CUP    = 9'd265;
  localparam logic [KeyW-1:0] KEY_CDOWN  = 9'd266;
  localparam logic [KeyW-1:0] KEY_CRIGHT = 9'd267;
  localparam logic [KeyW-1:0] KEY_CLEFT  = 9'd268;

  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_ESC   = 6'b000010,
    PH_SEQ   = 6'b000100,
    PH_DIGIT = 6'b001000,
    PH_SEMI  = 6'b010000,
    PH_MOD   = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [ByteW-1:0] first_seq_byte;
    logic [ByteW-1:0] second_seq_byte;
    logic [ByteW-1:0] modifier_byte;
  } dec_state_t;

  typedef struct packed {
    logic            emit;
    logic [KeyW-1:0] key_code;
  } dec_result_t;

  function automatic logic [KeyW-1:0] csi_letter(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    case (b)
      CH_A:    k = KEY_UP;
      CH_B:    k = KEY_DOWN;
      CH_C:    k = KEY_RIGHT;
      CH_D:    k = KEY_LEFT;
      CH_H:    k = KEY_HOME;
      CH_F:    k = KEY_END;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] tilde_digit(input logic [ByteW-1:0] d);
    logic [KeyW-1:0] k;
    case (d)
      CH_1, CH_7: k = KEY_HOME;
      CH_3:       k = KEY_DEL;
      CH_4, CH_8: k = KEY_END;
      CH_5:       k = KEY_PGUP;
      CH_6:       k = KEY_PGDN;
      default:    k = KEY_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [KeyW-1:0] ctrl_letter(input logic [ByteW-1:0] b);
    logic [KeyW-1:0] k;
    case (b)
      CH_A:    k = KEY_CUP;
      CH_B:    k = KEY_CDOWN;
      CH_C:    k = KEY_CRIGHT;
      CH_D:    k = KEY_CLEFT;
      default: k = KEY_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: hdl/tekd_decode.sv
module tekd_decode
  import tekd_pkg::*;
(
  input  dec_state_t       st,
  input  logic             kind,
  input  logic [ByteW-1:0] rx_byte,
  output dec_state_t       st_nxt,
  output dec_result_t      res
);

  logic seq_active;

  always_comb begin
    seq_active = (st.phase == PH_ESC) || (st.phase == PH_SEQ) || (st.phase == PH_DIGIT) ||
                 (st.phase == PH_SEMI) || (st.phase == PH_MOD);
    st_nxt       = st;
    res.emit     = 1'b0;
    res.key_code = KEY_NONE;
    if (seq_active && kind) begin
      st_nxt.phase = PH_IDLE;
      res.emit     = 1'b1;
      res.key_code = KEY_ESC;
    end else begin
      case (st.phase)
        PH_ESC: begin
          st_nxt.first_seq_byte = rx_byte;
          st_nxt.phase          = PH_SEQ;
        end
        PH_SEQ: begin
          st_nxt.second_seq_byte = rx_byte;
          st_nxt.phase           = PH_IDLE;
          res.emit               = 1'b1;
          if (st.first_seq_byte == CH_LBRK) begin
            if (rx_byte >= CH_0 && rx_byte <= CH_9) begin
              st_nxt.phase = PH_DIGIT;
              res.emit     = 1'b0;
            end else begin
              res.key_code = csi_letter(rx_byte);
            end
          end else if (st.first_seq_byte == CH_O) begin
            if (rx_byte == CH_H) begin
              res.key_code = KEY_HOME;
            end else if (rx_byte == CH_F) begin
              res.key_code = KEY_END;
            end
          end else begin
            res.key_code = KEY_ESC;
          end
        end
        PH_DIGIT: begin
          if (rx_byte == CH_SEMI) begin
            st_nxt.phase = PH_SEMI;
          end else begin
            st_nxt.phase = PH_IDLE;
            res.emit     = 1'b1;
            if (rx_byte == CH_TILDE) begin
              res.key_code = tilde_digit(st.second_seq_byte);
            end
          end
        end
        PH_SEMI: begin
          st_nxt.modifier_byte = rx_byte;
          st_nxt.phase         = PH_MOD;
        end
        PH_MOD: begin
          st_nxt.phase = PH_IDLE;
          res.emit     = 1'b1;
          if (st.second_seq_byte == CH_1 && st.modifier_byte == CH_5) begin
            res.key_code = ctrl_letter(rx_byte);
          end
        end
        default: begin
          st_nxt.phase = PH_IDLE;
          if (!kind) begin
            if (rx_byte == CH_ESC) begin
              st_nxt.phase = PH_ESC;
            end else begin
              res.emit     = 1'b1;
              res.key_code = {1'b0, rx_byte};
            end
          end
        end
      endcase
    end
  end

endmodule

// File: hdl/terminal_escape_key_decoder_unit.sv
// terminal escape key decoder
// input channel: in_valid / in_stall with in_kind (0 = byte, 1 = read gap) and in_rx_byte;
//   a transaction is taken at a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with out_key_code (0-255 raw byte, 256-268 keys)
// a plain byte gives its own code at once; an escape sequence gives one code on the
//   byte that completes it, and bytes inside a sequence give no output transaction
// path: the input transaction lands in an input register, the decode state machine
//   runs on it and writes the result register, which drives out_valid and out_key_code
// throughput: one input transaction per cycle while out_stall holds no result, set by
//   the combinational decode step between the input register and the result register
// stall: while out_stall holds a result, the input register fills and then in_stall
//   rises; no transaction is lost or repeated, and out_key_code holds while stalled
// reset: rst_n low at a clock edge empties both registers and returns the decoder
//   to idle with its stored sequence bytes cleared
module terminal_escape_key_decoder_unit
  import tekd_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_kind,
  input  logic [ByteW-1:0] in_rx_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [KeyW-1:0] out_key_code
);

  logic             in_valid_r;
  logic             kind_r;
  logic [ByteW-1:0] byte_r;
  dec_state_t       st_r;
  dec_state_t       st_nxt;
  dec_result_t      res;
  logic             out_valid_r;
  logic [KeyW-1:0]  key_r;
  logic             out_free;
  logic             step;

  assign out_free = !out_valid_r || !out_stall;
  assign step     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  tekd_decode u_decode (
    .st      (st_r),
    .kind    (kind_r),
    .rx_byte (byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      kind_r <= in_kind;
      byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase           <= PH_IDLE;
      st_r.first_seq_byte  <= '0;
      st_r.second_seq_byte <= '0;
      st_r.modifier_byte   <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && res.emit) begin
      key_r <= res.key_code;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_key_code = key_r;

endmodule

// File: tb/tekd_key_checker.sv
`timescale 1ns / 100ps

module tekd_key_checker
  import tekd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_kind,
  input  logic [ByteW-1:0] in_rx_byte,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [KeyW-1:0]  out_key_code,
  output int               pending_keys,
  output int               mismatches
);

  phase_t           seq_phase;
  logic [ByteW-1:0] lead_byte;
  logic [ByteW-1:0] param_byte;
  logic [ByteW-1:0] mod_byte;
  logic [KeyW-1:0]  expected_keys[$];

  task automatic decode_step(input logic gap, input logic [ByteW-1:0] b,
                             output logic emit, output logic [KeyW-1:0] key);
    emit = 1'b1;
    key  = KEY_NONE;
    if (seq_phase == PH_IDLE) begin
      if (gap) begin
        emit = 1'b0;
      end else if (b == CH_ESC) begin
        emit = 1'b0;
        seq_phase = PH_ESC;
      end else begin
        key = {1'b0, b};
      end
    end else if (gap) begin
      key = KEY_ESC;
      seq_phase = PH_IDLE;
    end else begin
      case (seq_phase)
        PH_ESC: begin
          lead_byte = b;
          seq_phase = PH_SEQ;
          emit = 1'b0;
        end
        PH_SEQ: begin
          param_byte = b;
          if (lead_byte == CH_LBRK) begin
            if (b >= CH_0 && b <= CH_9) begin
              seq_phase = PH_DIGIT;
              emit = 1'b0;
            end else begin
              case (b)
                CH_A:    key = KEY_UP;
                CH_B:    key = KEY_DOWN;
                CH_C:    key = KEY_RIGHT;
                CH_D:    key = KEY_LEFT;
                CH_H:    key = KEY_HOME;
                CH_F:    key = KEY_END;
                default: key = KEY_NONE;
              endcase
            end
          end else if (lead_byte == CH_O) begin
            if (b == CH_H) key = KEY_HOME;
            else if (b == CH_F) key = KEY_END;
          end else begin
            key = KEY_ESC;
          end
        end
        PH_DIGIT: begin
          if (b == CH_TILDE) begin
            case (param_byte)
              CH_1, CH_7: key = KEY_HOME;
              CH_3:       key = KEY_DEL;
              CH_4, CH_8: key = KEY_END;
              CH_5:       key = KEY_PGUP;
              CH_6:       key = KEY_PGDN;
              default:    key = KEY_NONE;
            endcase
          end else if (b == CH_SEMI) begin
            seq_phase = PH_SEMI;
            emit = 1'b0;
          end
        end
        PH_SEMI: begin
          mod_byte = b;
          seq_phase = PH_MOD;
          emit = 1'b0;
        end
        default: begin
          if (param_byte == CH_1 && mod_byte == CH_5) begin
            case (b)
              CH_A:    key = KEY_CUP;
              CH_B:    key = KEY_CDOWN;
              CH_C:    key = KEY_CRIGHT;
              CH_D:    key = KEY_CLEFT;
              default: key = KEY_NONE;
            endcase
          end
        end
      endcase
      if (emit) seq_phase = PH_IDLE;
    end
  endtask

  always @(posedge clk) begin
    logic            emit;
    logic [KeyW-1:0] key;
    logic [KeyW-1:0] want;
    if (!rst_n) begin
      seq_phase  = PH_IDLE;
      lead_byte  = '0;
      param_byte = '0;
      mod_byte   = '0;
      expected_keys.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_keys.size() == 0) begin
          $error("out_key_code: no transaction expected, actual %0d", out_key_code);
          mismatches++;
        end else begin
          want = expected_keys.pop_front();
          if (out_key_code !== want) begin
            $error("out_key_code: expected %0d, actual %0d", want, out_key_code);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_step(in_kind, in_rx_byte, emit, key);
        if (emit) expected_keys.push_back(key);
      end
    end
    pending_keys = expected_keys.size();
  end

endmodule

// File: tb/terminal_escape_key_decoder_unit_tb.sv
`timescale 1ns / 100ps

module terminal_escape_key_decoder_unit_tb
  import tekd_pkg::*;
();

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_GAP  = 1'b1;
  localparam int   NumItems  = 875;
  localparam int   CalmTail  = 100;
  localparam int   HoldAt    = 300;
  localparam int   HoldLen   = 60;
  localparam int   DrainAt   = 550;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] data;
  } rx_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_kind = KIND_BYTE;
  logic [ByteW-1:0] in_rx_byte = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [KeyW-1:0]  out_key_code;

  int       pending_keys;
  int       mismatches;
  int       sent_cnt = 0;
  rx_item_t rx_items[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  terminal_escape_key_decoder_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code)
  );

  tekd_key_checker key_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_rx_byte   (in_rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_code (out_key_code),
    .pending_keys (pending_keys),
    .mismatches   (mismatches)
  );

  function automatic logic [ByteW-1:0] mostly(input logic [ByteW-1:0] want);
    return ($urandom_range(0, 7) == 0) ? ByteW'($urandom) : want;
  endfunction

  function automatic void push_byte(input logic [ByteW-1:0] b);
    rx_items.push_back('{kind: KIND_BYTE, data: b});
  endfunction

  function automatic void push_gap();
    rx_items.push_back('{kind: KIND_GAP, data: ByteW'($urandom)});
  endfunction

  // a sequence is sometimes cut short by a read gap
  function automatic void push_seq(input logic [ByteW-1:0] sq[$], input bit may_cut);
    int cut;
    cut = sq.size();
    if (may_cut && sq.size() > 1 && $urandom_range(0, 9) == 0)
      cut = $urandom_range(1, sq.size() - 1);
    for (int i = 0; i < cut; i++) push_byte(sq[i]);
    if (cut < sq.size()) push_gap();
  endfunction

  task automatic build_stimulus();
    logic [ByteW-1:0] sq[$];
    logic [ByteW-1:0] csi_end[6];
    logic [ByteW-1:0] ctrl_end[4];
    int               pick;
    csi_end  = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
    ctrl_end = '{CH_A, CH_B, CH_C, CH_D};
    push_byte(8'h00);
    push_byte(8'hff);
    push_gap();
    sq = {CH_ESC, CH_LBRK, CH_A};
    push_seq(sq, 1'b0);
    sq = {CH_ESC, CH_O, CH_H};
    push_seq(sq, 1'b0);
    sq = {CH_ESC, CH_LBRK, CH_3, CH_TILDE};
    push_seq(sq, 1'b0);
    sq = {CH_ESC, CH_LBRK, CH_1, CH_SEMI, CH_5, CH_C};
    push_seq(sq, 1'b0);
    push_byte(CH_ESC);
    push_gap();
    sq = {CH_ESC, 8'h71, 8'h7a};
    push_seq(sq, 1'b0);
    sq = {CH_ESC, CH_LBRK, CH_9, CH_TILDE};
    push_seq(sq, 1'b0);
    while (rx_items.size() < NumItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        push_byte(ByteW'($urandom));
      end else if (pick < 30) begin
        push_gap();
      end else begin
        if (pick < 48)
          sq = {CH_ESC, CH_LBRK, mostly(csi_end[$urandom_range(0, 5)])};
        else if (pick < 58)
          sq = {CH_ESC, CH_O, mostly($urandom_range(0, 1) ? CH_H : CH_F)};
        else if (pick < 72)
          sq = {CH_ESC, CH_LBRK, ByteW'(CH_0 + $urandom_range(0, 9)), mostly(CH_TILDE)};
        else if (pick < 90)
          sq = {CH_ESC, CH_LBRK, mostly(CH_1), CH_SEMI, mostly(CH_5),
                mostly(ctrl_end[$urandom_range(0, 3)])};
        else
          sq = {CH_ESC, ByteW'($urandom), ByteW'($urandom)};
        push_seq(sq, 1'b1);
      end
    end
  endtask

  initial begin
    int wait_cnt;
    build_stimulus();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    for (int idx = 0; idx < rx_items.size(); idx++) begin
      if (idx == DrainAt ||
          (idx < rx_items.size() - CalmTail && $urandom_range(0, 7) == 0)) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        while (idx == DrainAt && pending_keys != 0) @(negedge clk);
      end
      in_valid   <= 1'b1;
      in_kind    <= rx_items[idx].kind;
      in_rx_byte <= rx_items[idx].data;
      do @(posedge clk); while (in_stall);
      sent_cnt++;
      @(negedge clk);
    end
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (pending_keys != 0 && wait_cnt < 2000) begin
      @(negedge clk);
      wait_cnt++;
    end
    repeat (8) @(negedge clk);
    if (pending_keys != 0)
      $error("out_key_code: %0d transactions never arrived", pending_keys);
    if (mismatches == 0 && pending_keys == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side backpressure, one long hold to fill the pipe
  initial begin
    int  burst;
    bit  held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && sent_cnt >= HoldAt) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldLen) @(negedge clk);
        out_stall <= 1'b0;
      end else if (sent_cnt < rx_items.size() - CalmTail &&
                   ((sent_cnt / 64) % 3 != 2) && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
